FILE: rtl/assert_macros.svh
// assertion macros used by bhte_back.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define CHK_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define CHK_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/bhte_pkg.sv
// shared types, codes and helpers of the hash table engine
// no dependencies
package bhte_pkg;

    localparam logic [1:0] ACT_GET = 2'd0;
    localparam logic [1:0] ACT_SET = 2'd1;
    localparam logic [1:0] ACT_CLR = 2'd2;

    localparam logic [1:0] ST_UNUSED = 2'd0;
    localparam logic [1:0] ST_LIVE   = 2'd1;
    localparam logic [1:0] ST_TOMB   = 2'd2;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_ABSENT = 2'd1;
    localparam logic [1:0] STAT_FULL   = 2'd2;

    localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;

    // one operation as handed from the hashing front to the table back end
    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] key;
        logic [3:0]  len;
        logic [63:0] val;
        logic [63:0] hash;
    } t_job;

    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic ci);
        logic [7:0] r;
        r = b;
        if (ci && b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

    function automatic logic [63:0] fold_key(input logic [63:0] k, input logic ci);
        logic [63:0] r;
        for (int i = 0; i < 8; i++) begin
            r[8*i +: 8] = fold_byte(k[8*i +: 8], ci);
        end
        return r;
    endfunction

endpackage

FILE: rtl/bhte_front.sv
// front end: takes an item, masks the key, runs fnv-1a one byte a cycle,
// then reduces the hash to home slot and probe step one 16-bit digit at a time; uses bhte_pkg
module bhte_front import bhte_pkg::*; #(
    parameter int SLOT_COUNT = 1021,
    parameter int KEY_BYTES  = 8,
    parameter int VALUE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_action,
    input  logic [63:0]                   i_key,
    input  logic [3:0]                    i_len,
    input  logic [31:0]                   i_value,
    input  logic                          i_ci,
    input  logic                          i_hold,
    output logic                          o_valid,
    input  logic                          i_ready,
    output t_job                          o_job,
    output logic [$clog2(SLOT_COUNT)-1:0] o_home,
    output logic [$clog2(SLOT_COUNT)-1:0] o_step
);
    localparam int AW = $clog2(SLOT_COUNT);
    localparam logic [63:0] VMASK = {64{1'b1}} >> (64 - VALUE_BITS);
    // floor(2^32 / m): quotient estimate is exact or one low
    localparam logic [32:0] RC_HOME = 33'((65'd1 << 32) / 65'(SLOT_COUNT));
    localparam logic [32:0] RC_STEP = 33'((65'd1 << 32) / 65'(SLOT_COUNT - 2));

    typedef enum logic [1:0] {F_IDLE, F_HASH, F_MOD, F_OUT} t_fstate;

    t_fstate       r_state;
    t_job          r_job;
    logic [3:0]    r_i;
    logic [1:0]    r_dig;
    logic          r_ph;
    logic [31:0]   r_qh;
    logic [31:0]   r_qs;
    logic [AW-1:0] r_home;
    logic [AW-1:0] r_step;

    logic [3:0]    n_len;
    logic [63:0]   n_key;
    logic [2:0]    n_idx;
    logic [63:0]   n_hx;
    logic [63:0]   n_hash;
    logic [15:0]   n_dig;
    logic [31:0]   n_vh;
    logic [31:0]   n_vs;
    logic [31:0]   n_qh;
    logic [31:0]   n_qs;
    logic [31:0]   n_rh;
    logic [31:0]   n_rs;

    assign o_ready = (r_state == F_IDLE) && !i_hold;
    assign o_valid = (r_state == F_OUT);
    assign o_job   = r_job;
    assign o_home  = r_home;
    assign o_step  = r_step + AW'(1);

    always_comb begin
        n_len = (i_len > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : i_len;
        for (int i = 0; i < 8; i++) begin
            n_key[8*i +: 8] = (4'(i) < n_len) ? i_key[8*i +: 8] : 8'h00;
        end
        n_idx  = 3'(r_i - 4'd1);
        n_hx   = r_job.hash ^ {56'b0, fold_byte(r_job.key[8*n_idx +: 8], i_ci)};
        // times 2^40 + 0x1b3
        n_hash = (n_hx << 40) + (n_hx << 8) + (n_hx << 7) + (n_hx << 5)
               + (n_hx << 4) + (n_hx << 1) + n_hx;
        // remainder so far shifted up by one 16-bit digit, top digit first
        n_dig  = r_job.hash[16*r_dig +: 16];
        n_vh   = {16'(r_home), n_dig};
        n_vs   = {16'(r_step), n_dig};
        n_qh   = 32'((65'(n_vh) * 65'(RC_HOME)) >> 32);
        n_qs   = 32'((65'(n_vs) * 65'(RC_STEP)) >> 32);
        n_rh   = n_vh - r_qh * 32'(SLOT_COUNT);
        n_rs   = n_vs - r_qs * 32'(SLOT_COUNT - 2);
        if (n_rh >= 32'(SLOT_COUNT)) begin
            n_rh = n_rh - 32'(SLOT_COUNT);
        end
        if (n_rs >= 32'(SLOT_COUNT - 2)) begin
            n_rs = n_rs - 32'(SLOT_COUNT - 2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_job.action <= i_action;
                        r_job.key    <= n_key;
                        r_job.len    <= n_len;
                        r_job.val    <= 64'(i_value) & VMASK;
                        r_job.hash   <= FNV_BASIS;
                        r_i          <= n_len;
                        r_dig        <= 2'd3;
                        r_ph         <= 1'b0;
                        r_home       <= '0;
                        r_step       <= '0;
                        r_state      <= (n_len == 4'd0) ? F_MOD : F_HASH;
                    end
                end
                F_HASH: begin
                    r_job.hash <= n_hash;
                    r_i        <= r_i - 4'd1;
                    if (r_i == 4'd1) begin
                        r_state <= F_MOD;
                    end
                end
                F_MOD: begin
                    r_ph <= ~r_ph;
                    if (!r_ph) begin
                        r_qh <= n_qh;
                        r_qs <= n_qs;
                    end else begin
                        r_home <= AW'(n_rh);
                        r_step <= AW'(n_rs);
                        r_dig  <= r_dig - 2'd1;
                        if (r_dig == 2'd0) begin
                            r_state <= F_OUT;
                        end
                    end
                end
                F_OUT: begin
                    if (i_ready) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/bhte_queue.sv
// small fifo between the front and the back end
// no dependencies
module bhte_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_valid,
    output logic             o_wr_ready,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_rd_valid,
    input  logic             i_rd_ready,
    output logic [WIDTH-1:0] o_rd_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;
    logic             n_wr;
    logic             n_rd;

    assign o_wr_ready = (r_cnt != CW'(DEPTH));
    assign o_rd_valid = (r_cnt != '0);
    assign o_rd_data  = r_mem[r_rp];
    assign n_wr = i_wr_valid && o_wr_ready;
    assign n_rd = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (n_wr) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (n_wr) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (n_rd) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (n_wr && !n_rd) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (n_rd && !n_wr) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

FILE: rtl/bhte_back.sv
// back end: slot memories, lookup, brent placement, tombstones, clear sweep
// and the result register; uses bhte_pkg and assert_macros.svh
`include "assert_macros.svh"
module bhte_back import bhte_pkg::*; #(
    parameter int SLOT_COUNT = 1021,
    parameter int VALUE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    output logic                          o_job_ready,
    input  t_job                          i_job,
    input  logic [$clog2(SLOT_COUNT)-1:0] i_home,
    input  logic [$clog2(SLOT_COUNT)-1:0] i_step,
    input  logic                          i_ci,
    output logic                          o_busy,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_status,
    output logic [31:0]                   o_value,
    output logic [9:0]                    o_live
);
    localparam int AW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int VB = VALUE_BITS;
    localparam int EW = 64 + AW + 64 + 4 + VB;
    localparam int LOAD_LIMIT = (SLOT_COUNT >> 1) + (SLOT_COUNT >> 2) + (SLOT_COUNT >> 3);

    typedef enum logic [3:0] {
        B_CLR, B_IDLE, B_LK_RD, B_LK_EV, B_ACT, B_P1_RD, B_P1_EV, B_P2_ORD,
        B_P2_OEV, B_P2_IRD, B_P2_IEV, B_P2_NEXT, B_MOVE, B_INS, B_RESP
    } t_bstate;

    logic [1:0]    r_st_mem [SLOT_COUNT];
    logic [EW-1:0] r_en_mem [SLOT_COUNT];
    logic [1:0]    r_st_q;
    logic [EW-1:0] r_en_q;

    t_bstate       r_state;
    t_job          r_job;
    logic [AW-1:0] r_home;
    logic [AW-1:0] r_step;
    logic [AW-1:0] r_h;
    logic [AW-1:0] r_hm;
    logic [AW-1:0] r_qm;
    logic [AW-1:0] r_slot;
    logic [AW-1:0] r_worst;
    logic [AW-1:0] r_mold;
    logic [AW-1:0] r_mnew;
    logic [AW-1:0] r_clr_addr;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_lw;
    logic [CW-1:0] r_len;
    logic [CW-1:0] r_lm;
    logic [CW-1:0] r_lem;
    logic          r_lem_set;
    logic          r_found;
    logic          r_clr_resp;
    logic [EW-1:0] r_cand;
    logic [EW-1:0] r_mold_ent;
    logic [CW-1:0] r_live;
    logic [1:0]    r_status;
    logic [VB-1:0] r_vout;
    logic          r_m_valid;
    logic [1:0]    r_m_status;
    logic [31:0]   r_m_value;
    logic [9:0]    r_m_live;

    logic          n_rd_en;
    logic [AW-1:0] n_rd_addr;
    logic          n_st_we;
    logic [AW-1:0] n_st_wa;
    logic [1:0]    n_st_wd;
    logic          n_en_we;
    logic [AW-1:0] n_en_wa;
    logic [EW-1:0] n_en_wd;
    logic [EW-1:0] n_new_ent;
    logic          n_match;
    logic [AW-1:0] n_h_nxt;
    logic [AW-1:0] n_hm_nxt;
    logic [AW-1:0] n_qm_hm;
    logic [CW-1:0] n_len1;
    logic          n_m_load;
    logic          n_h_ok;

    function automatic logic [AW-1:0] step_idx(input logic [AW-1:0] a, input logic [AW-1:0] q);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, q};
        if (s >= (AW+1)'(SLOT_COUNT)) begin
            s = s - (AW+1)'(SLOT_COUNT);
        end
        return AW'(s);
    endfunction

    // entry layout from the top: hash, step, key, length, value
    assign n_new_ent = {r_job.hash, r_step, r_job.key, r_job.len, VB'(r_job.val)};
    assign n_match = (r_st_q == ST_LIVE) && (r_en_q[EW-1 -: 64] == r_job.hash)
                  && (r_en_q[VB +: 4] == r_job.len)
                  && (fold_key(r_en_q[VB+4 +: 64], i_ci) == fold_key(r_job.key, i_ci));
    assign n_h_nxt  = step_idx(r_h, r_step);
    assign n_hm_nxt = step_idx(r_hm, r_qm);
    assign n_qm_hm  = step_idx(r_h, r_en_q[VB+68 +: AW]);
    assign n_len1   = r_len + CW'(1);
    assign n_m_load = (r_state == B_RESP) && (!r_m_valid || i_out_ready);
    assign n_h_ok   = (r_state == B_IDLE) || (r_state == B_CLR) || (r_h < AW'(SLOT_COUNT));

    assign o_job_ready = (r_state == B_IDLE);
    assign o_busy      = (r_state == B_CLR) && !r_clr_resp;
    assign o_out_valid = r_m_valid;
    assign o_status    = r_m_status;
    assign o_value     = r_m_value;
    assign o_live      = r_m_live;

    always_comb begin
        n_rd_en   = 1'b0;
        n_rd_addr = r_h;
        n_st_we   = 1'b0;
        n_st_wa   = r_slot;
        n_st_wd   = ST_LIVE;
        n_en_we   = 1'b0;
        n_en_wa   = r_slot;
        n_en_wd   = n_new_ent;
        unique case (r_state)
            B_CLR: begin
                n_st_we = 1'b1;
                n_st_wa = r_clr_addr;
                n_st_wd = ST_UNUSED;
            end
            B_LK_RD, B_P1_RD, B_P2_ORD: begin
                n_rd_en = 1'b1;
            end
            B_P2_IRD: begin
                n_rd_en   = 1'b1;
                n_rd_addr = r_hm;
            end
            B_ACT: begin
                if (r_job.action == ACT_SET && r_found) begin
                    if (r_job.val != 64'd0) begin
                        n_en_we = 1'b1;
                        n_en_wa = r_h;
                        n_en_wd = {r_en_q[EW-1:VB], VB'(r_job.val)};
                    end else begin
                        n_st_we = 1'b1;
                        n_st_wa = r_h;
                        n_st_wd = ST_TOMB;
                    end
                end
            end
            B_MOVE: begin
                n_st_we = 1'b1;
                n_st_wa = r_mnew;
                n_en_we = 1'b1;
                n_en_wa = r_mnew;
                n_en_wd = r_mold_ent;
            end
            B_INS: begin
                n_st_we = 1'b1;
                n_en_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (n_st_we) begin
            r_st_mem[n_st_wa] <= n_st_wd;
        end
        if (n_en_we) begin
            r_en_mem[n_en_wa] <= n_en_wd;
        end
        if (n_rd_en) begin
            r_st_q <= r_st_mem[n_rd_addr];
            r_en_q <= r_en_mem[n_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_CLR;
            r_clr_addr <= '0;
            r_clr_resp <= 1'b0;
            r_live     <= '0;
            r_m_valid  <= 1'b0;
            r_m_status <= STAT_OK;
            r_m_value  <= '0;
            r_m_live   <= '0;
        end else begin
            if (n_m_load) begin
                r_m_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                B_CLR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(SLOT_COUNT - 1)) begin
                        r_live  <= '0;
                        r_state <= r_clr_resp ? B_RESP : B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (i_job_valid) begin
                        r_job    <= i_job;
                        r_home   <= i_home;
                        r_step   <= i_step;
                        r_h      <= i_home;
                        r_n      <= '0;
                        r_found  <= 1'b0;
                        r_status <= STAT_OK;
                        r_vout   <= '0;
                        r_state  <= (i_job.action == ACT_GET || i_job.action == ACT_SET)
                                  ? B_LK_RD : B_ACT;
                    end
                end
                B_LK_RD: r_state <= B_LK_EV;
                B_LK_EV: begin
                    if (r_st_q == ST_UNUSED) begin
                        r_state <= B_ACT;
                    end else if (n_match) begin
                        r_found <= 1'b1;
                        r_state <= B_ACT;
                    end else if (n_h_nxt == r_home || r_n + CW'(1) == CW'(SLOT_COUNT)) begin
                        r_state <= B_ACT;
                    end else begin
                        r_h     <= n_h_nxt;
                        r_n     <= r_n + CW'(1);
                        r_state <= B_LK_RD;
                    end
                end
                B_ACT: begin
                    priority if (r_job.action == ACT_CLR) begin
                        r_clr_addr <= '0;
                        r_clr_resp <= 1'b1;
                        r_state    <= B_CLR;
                    end else if (r_job.action == ACT_SET && !r_found && r_job.val != 64'd0
                                 && r_live < CW'(LOAD_LIMIT)) begin
                        r_h     <= r_home;
                        r_n     <= '0;
                        r_lw    <= CW'(1);
                        r_state <= B_P1_RD;
                    end else begin
                        r_state <= B_RESP;
                        if (r_job.action == ACT_GET) begin
                            if (r_found) begin
                                r_vout <= r_en_q[VB-1:0];
                            end else begin
                                r_status <= STAT_ABSENT;
                            end
                        end else if (r_job.action == ACT_SET) begin
                            if (r_found) begin
                                if (r_job.val == 64'd0) begin
                                    r_live <= r_live - CW'(1);
                                end
                            end else if (r_job.val != 64'd0) begin
                                r_status <= STAT_FULL;
                            end
                        end
                    end
                end
                B_P1_RD: r_state <= B_P1_EV;
                B_P1_EV: begin
                    if (r_st_q == ST_LIVE) begin
                        if (r_n + CW'(1) >= CW'(SLOT_COUNT)) begin
                            r_status <= STAT_FULL;
                            r_state  <= B_RESP;
                        end else begin
                            r_n     <= r_n + CW'(1);
                            r_h     <= n_h_nxt;
                            r_lw    <= r_lw + CW'(1);
                            r_state <= B_P1_RD;
                        end
                    end else begin
                        r_worst <= r_h;
                        if (r_lw <= CW'(2)) begin
                            r_slot  <= r_h;
                            r_state <= B_INS;
                        end else begin
                            r_h       <= r_home;
                            r_len     <= CW'(1);
                            r_lem_set <= 1'b0;
                            r_found   <= 1'b0;
                            r_state   <= B_P2_ORD;
                        end
                    end
                end
                B_P2_ORD: r_state <= B_P2_OEV;
                B_P2_OEV: begin
                    // step of the resident entry, kept with it in the entry memory
                    r_qm    <= r_en_q[VB+68 +: AW];
                    r_cand  <= r_en_q;
                    r_hm    <= n_qm_hm;
                    r_lm    <= CW'(1);
                    r_state <= B_P2_IRD;
                end
                B_P2_IRD: r_state <= B_P2_IEV;
                B_P2_IEV: begin
                    if (r_st_q != ST_LIVE) begin
                        r_mold     <= r_h;
                        r_mnew     <= r_hm;
                        r_lem      <= r_lm;
                        r_lem_set  <= 1'b1;
                        r_found    <= 1'b1;
                        r_mold_ent <= r_cand;
                        r_state    <= B_P2_NEXT;
                    end else if ({1'b0, r_len} + {1'b0, r_lm} >= {1'b0, r_lw} - (CW+1)'(1)) begin
                        r_state <= B_P2_NEXT;
                    end else begin
                        r_hm    <= n_hm_nxt;
                        r_lm    <= r_lm + CW'(1);
                        r_state <= B_P2_IRD;
                    end
                end
                B_P2_NEXT: begin
                    r_h   <= n_h_nxt;
                    r_len <= n_len1;
                    if (n_len1 < r_lw - CW'(1) && (!r_lem_set || n_len1 < r_lem)) begin
                        r_state <= B_P2_ORD;
                    end else if (r_found) begin
                        r_slot  <= r_mold;
                        r_state <= B_MOVE;
                    end else begin
                        r_slot  <= r_worst;
                        r_state <= B_INS;
                    end
                end
                B_MOVE: r_state <= B_INS;
                B_INS: begin
                    r_live  <= r_live + CW'(1);
                    r_state <= B_RESP;
                end
                B_RESP: begin
                    if (n_m_load) begin
                        r_m_status <= r_status;
                        r_m_value  <= 32'(r_vout);
                        r_m_live   <= 10'(r_live);
                        r_clr_resp <= 1'b0;
                        r_state    <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    `CHK_AT(a_live_limit, i_clk, i_rst_n, r_live <= CW'(LOAD_LIMIT), "live count above load limit")
    `CHK_AT(a_probe_range, i_clk, i_rst_n, n_h_ok, "probe index out of table")
    `CHK_NEXT(a_ins_count, i_clk, i_rst_n, r_state == B_INS, r_live == CW'($past(r_live) + CW'(1)), "insert did not count")

endmodule

FILE: rtl/brent_hash_table_engine.sv
// flow: the front masks and hashes the key byte by byte and reduces the hash to home slot
// and step; the back end then probes slot by slot, and an insert also runs the brent search
// concurrency: one item at a time per part, the queue between them letting the front take
// another item while the back end works; a clear item sweeps every slot
// reset: synchronous active low; a clearing pass over every slot follows,
// during which s_axis_tready stays low
module brent_hash_table_engine import bhte_pkg::*; #(
    parameter int SLOT_COUNT = 1021,
    parameter int KEY_BYTES  = 8,
    parameter int VALUE_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,   // key_bytes, key_length, value_in, zero pad
    input  logic [1:0]   s_axis_tuser,   // action
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [47:0]  m_axis_tdata,   // value_out, entries_used, zero pad
    output logic [1:0]   m_axis_tuser,   // status
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int AW = $clog2(SLOT_COUNT);
    localparam int QW = $bits(t_job) + 2 * AW;

    logic          r_ci;
    logic          n_busy;
    logic          n_f_valid;
    logic          n_f_ready;
    t_job          n_f_job;
    logic [AW-1:0] n_f_home;
    logic [AW-1:0] n_f_step;
    logic          n_q_valid;
    logic          n_q_ready;
    logic [QW-1:0] n_q_data;
    logic [1:0]    n_status;
    logic [31:0]   n_value;
    logic [9:0]    n_live;

    assign pready = 1'b1;
    assign prdata = {31'b0, r_ci};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ci <= 1'b0;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00 && n_live == 10'd0) begin
            r_ci <= pwdata[0];
        end
    end

    bhte_front #(
        .SLOT_COUNT (SLOT_COUNT),
        .KEY_BYTES  (KEY_BYTES),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_action (s_axis_tuser),
        .i_key    (s_axis_tdata[63:0]),
        .i_len    (s_axis_tdata[67:64]),
        .i_value  (s_axis_tdata[99:68]),
        .i_ci     (r_ci),
        .i_hold   (n_busy),
        .o_valid  (n_f_valid),
        .i_ready  (n_f_ready),
        .o_job    (n_f_job),
        .o_home   (n_f_home),
        .o_step   (n_f_step)
    );

    bhte_queue #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (n_f_valid),
        .o_wr_ready (n_f_ready),
        .i_wr_data  ({n_f_job, n_f_home, n_f_step}),
        .o_rd_valid (n_q_valid),
        .i_rd_ready (n_q_ready),
        .o_rd_data  (n_q_data)
    );

    bhte_back #(
        .SLOT_COUNT (SLOT_COUNT),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (n_q_valid),
        .o_job_ready (n_q_ready),
        .i_job       (n_q_data[QW-1 -: $bits(t_job)]),
        .i_home      (n_q_data[2*AW-1:AW]),
        .i_step      (n_q_data[AW-1:0]),
        .i_ci        (r_ci),
        .o_busy      (n_busy),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_status    (n_status),
        .o_value     (n_value),
        .o_live      (n_live)
    );

    assign m_axis_tuser = n_status;
    assign m_axis_tdata = {6'b0, n_live, n_value};

endmodule

FILE: tb/tb_brent_hash_table_engine.sv
// self-checking testbench of the brent hash table engine: directed table, then random traffic
// depends on rtl/bhte_pkg.sv and rtl/brent_hash_table_engine.sv
`timescale 1ns / 1ps

module tb_brent_hash_table_engine;
    import bhte_pkg::*;

    localparam int          TBL_SIZE   = 1021;
    localparam int          LOAD_LIMIT = (TBL_SIZE >> 1) + (TBL_SIZE >> 2) + (TBL_SIZE >> 3);
    localparam logic [63:0] FNV_PRIME  = 64'd1099511628211;
    localparam logic [1:0]  ACT_BAD    = 2'd3;
    localparam logic [1:0]  REG_CASE   = 2'd0;
    localparam int          STALL_MAX  = 400000;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value;
        logic [9:0]  used;
    } t_reply;

    typedef struct {
        logic [1:0]  act;
        logic [63:0] key;
        logic [3:0]  len;
        logic [31:0] val;
        t_reply      reply;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [103:0] s_axis_tdata = '0;   // key_bytes, key_length, value_in, zero pad
    logic [1:0] s_axis_tuser = '0;     // action
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;         // value_out, entries_used, zero pad
    logic [1:0] m_axis_tuser;          // status
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // predictor state
    logic [1:0]  tbl_state [TBL_SIZE];
    logic [63:0] tbl_hash  [TBL_SIZE];
    logic [63:0] tbl_key   [TBL_SIZE];
    logic [3:0]  tbl_len   [TBL_SIZE];
    logic [31:0] tbl_val   [TBL_SIZE];
    int          tbl_live;
    logic        fold_case;

    t_reply pending_replies[$];
    t_row   table_rows[$];
    logic [63:0] key_pool [24];
    logic [3:0]  len_pool [24];
    int errors = 0;
    int n_items = 0;
    int n_replies = 0;
    int n_full = 0;
    int n_found = 0;
    int stall_cnt = 0;
    bit no_idle = 1'b0;

    brent_hash_table_engine dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [7:0] lower_byte(logic [7:0] b);
        if (fold_case && b >= 8'h41 && b <= 8'h5A) return b + 8'h20;
        return b;
    endfunction

    function automatic logic [63:0] lower_key(logic [63:0] k, int len);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < len; i++) r[8*i +: 8] = lower_byte(k[8*i +: 8]);
        return r;
    endfunction

    function automatic logic [63:0] fnv_hash(logic [63:0] k, int len);
        logic [63:0] h;
        h = 64'd14695981039346656037;
        for (int i = len - 1; i >= 0; i--) begin
            h = h ^ {56'd0, lower_byte(k[8*i +: 8])};
            h = h * FNV_PRIME;
        end
        return h;
    endfunction

    function automatic int find_slot(logic [63:0] k, int len, logic [63:0] h);
        int home, step, s;
        home = int'(h % TBL_SIZE);
        step = int'(h % (TBL_SIZE - 2)) + 1;
        s = home;
        for (int n = 0; n < TBL_SIZE; n++) begin
            if (tbl_state[s] == ST_UNUSED) break;
            if (tbl_state[s] == ST_LIVE && tbl_hash[s] == h && tbl_len[s] == len &&
                lower_key(tbl_key[s], len) == lower_key(k, len))
                return s;
            s = (s + step) % TBL_SIZE;
            if (s == home) break;
        end
        return -1;
    endfunction

    // brent placement: may move one live entry further along its own chain
    function automatic int brent_slot(logic [63:0] h);
        int home, step, s, worst, lw, n, len, qm, hm, lm;
        int mold, mnew;
        longint lem;
        home = int'(h % TBL_SIZE);
        step = int'(h % (TBL_SIZE - 2)) + 1;
        s = home; lw = 1; n = 0;
        mold = -1; mnew = -1; lem = 64'hFFFFFFFF;
        while (tbl_state[s] == ST_LIVE) begin
            n++;
            if (n >= TBL_SIZE) return -1;
            s = (s + step) % TBL_SIZE;
            lw++;
        end
        worst = s;
        if (lw <= 2) return worst;
        s = home;
        len = 1;
        do begin
            qm = int'(tbl_hash[s] % (TBL_SIZE - 2)) + 1;
            hm = (s + qm) % TBL_SIZE;
            lm = 1;
            forever begin
                if (tbl_state[hm] != ST_LIVE) begin
                    mold = s; mnew = hm; lem = lm;
                    break;
                end
                if (len + lm >= lw - 1) break;
                hm = (hm + qm) % TBL_SIZE;
                lm++;
            end
            s = (s + step) % TBL_SIZE;
            len++;
        end while (len < lw - 1 && len < lem);
        if (mold >= 0) begin
            tbl_state[mnew] = tbl_state[mold];
            tbl_hash[mnew]  = tbl_hash[mold];
            tbl_key[mnew]   = tbl_key[mold];
            tbl_len[mnew]   = tbl_len[mold];
            tbl_val[mnew]   = tbl_val[mold];
            return mold;
        end
        return worst;
    endfunction

    function automatic t_reply apply_op(logic [1:0] act, logic [63:0] key_in, logic [3:0] len_in,
                                        logic [31:0] val);
        t_reply r;
        int len, slot;
        logic [63:0] key, h;
        r = '0;
        len = (len_in > 8) ? 8 : int'(len_in);
        key = (len == 0) ? 64'd0 : key_in & (~64'd0 >> (64 - 8 * len));
        if (act == ACT_CLR) begin
            foreach (tbl_state[i]) tbl_state[i] = ST_UNUSED;
            tbl_live = 0;
        end else if (act == ACT_GET || act == ACT_SET) begin
            h = fnv_hash(key, len);
            slot = find_slot(key, len, h);
            if (act == ACT_GET) begin
                if (slot < 0) r.status = STAT_ABSENT;
                else r.value = tbl_val[slot];
            end else if (val != 0) begin
                if (slot >= 0) begin
                    tbl_val[slot] = val;
                end else if (tbl_live >= LOAD_LIMIT) begin
                    r.status = STAT_FULL;
                end else begin
                    slot = brent_slot(h);
                    if (slot < 0) begin
                        r.status = STAT_FULL;
                    end else begin
                        tbl_state[slot] = ST_LIVE;
                        tbl_hash[slot] = h;
                        tbl_key[slot] = key;
                        tbl_len[slot] = 4'(len);
                        tbl_val[slot] = val;
                        tbl_live++;
                    end
                end
            end else if (slot >= 0) begin
                tbl_state[slot] = ST_TOMB;
                tbl_live--;
            end
        end
        r.used = 10'(tbl_live);
        return r;
    endfunction

    task automatic send_op(logic [1:0] act, logic [63:0] key, logic [3:0] len, logic [31:0] val,
                           t_reply reply);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {4'd0, val, len, key};
        pending_replies.push_back(reply);
        do @(posedge i_clk); while (!s_axis_tready);
        n_items++;
    endtask

    task automatic predict_and_send(logic [1:0] act, logic [63:0] key, logic [3:0] len,
                                    logic [31:0] val);
        send_op(act, key, len, val, apply_op(act, key, len, val));
    endtask

    // registers only change with no item in flight
    task automatic write_case(logic [31:0] data);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= REG_CASE; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (tbl_live == 0) fold_case = data[0];
    endtask

    task automatic add_row(logic [1:0] act, logic [63:0] key, logic [3:0] len, logic [31:0] val,
                           logic [1:0] st, logic [31:0] vo, logic [9:0] used);
        t_row row;
        row.act = act; row.key = key; row.len = len; row.val = val;
        row.reply = '{status: st, value: vo, used: used};
        table_rows.push_back(row);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0: return 8'($urandom_range(8'h41, 8'h5A));
            1: return 8'($urandom_range(8'h61, 8'h7A));
            2: return 8'h00;
            3: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // keys mostly come from a small pool so gets and updates hit; case flips test folding
    task automatic random_key(output logic [63:0] key, output logic [3:0] len);
        int idx;
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        idx = $urandom_range(0, 23);
        if ($urandom_range(0, 9) < 6) begin
            key = key_pool[idx];
            len = len_pool[idx];
            for (int i = 0; i < 8; i++)
                if ($urandom_range(0, 1) && key[8*i +: 8] >= 8'h41 && key[8*i +: 8] <= 8'h5A)
                    key[8*i +: 8] = key[8*i +: 8] + 8'h20;
        end else begin
            for (int i = 0; i < 8; i++) key[8*i +: 8] = pick_byte();
            len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                              : 4'($urandom_range(0, 8));
            key_pool[idx] = key;
            len_pool[idx] = len;
        end
        for (int i = 0; i < 8; i++) if (i >= len) key[8*i +: 8] = noise[8*i +: 8];
    endtask

    task automatic random_ops(int count);
        logic [63:0] key;
        logic [3:0] len;
        logic [31:0] val;
        logic [1:0] act;
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 50) no_idle = ~no_idle;
            random_key(key, len);
            case ($urandom_range(0, 19))
                0: act = ACT_BAD;
                1, 2, 3, 4, 5, 6, 7, 8: act = ACT_GET;
                default: act = ACT_SET;
            endcase
            val = ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom;
            predict_and_send(act, key, len, val);
        end
        no_idle = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_reply want;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) stall_cnt <= 0;
        else stall_cnt <= stall_cnt + 1;
        if (stall_cnt > STALL_MAX) begin
            $display("%0t watchdog: no item moved for %0d cycles", $time, STALL_MAX);
            $display("brent_hash_table_engine regression: fail");
            $finish;
        end
        if (m_axis_tvalid && m_axis_tready) begin
            n_replies++;
            if (pending_replies.size() == 0) begin
                $display("%0t unexpected result status=%0d value=%h used=%0d", $time,
                         m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[41:32]);
                errors++;
            end else begin
                want = pending_replies.pop_front();
                if (want.status == STAT_FULL) n_full++;
                if (want.value != 0) n_found++;
                if (m_axis_tuser !== want.status) begin
                    $display("%0t status mismatch: expected %0d actual %0d", $time,
                             want.status, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[31:0] !== want.value) begin
                    $display("%0t value mismatch: expected %h actual %h", $time,
                             want.value, m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[41:32] !== want.used) begin
                    $display("%0t entries mismatch: expected %0d actual %0d", $time,
                             want.used, m_axis_tdata[41:32]);
                    errors++;
                end
            end
        end
    end

    // result side back-pressure
    initial begin
        int w;
        forever begin
            w = no_idle ? 0 : $urandom_range(0, 11);
            if (w > 0) begin
                m_axis_tready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        logic [63:0] key;
        t_reply r;
        foreach (tbl_state[i]) tbl_state[i] = ST_UNUSED;
        tbl_live = 0;
        fold_case = 1'b0;
        foreach (key_pool[i]) begin
            key_pool[i] = {$urandom, $urandom};
            len_pool[i] = 4'($urandom_range(0, 8));
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_case(32'hFFFF_FFFE);

        add_row(ACT_GET, 64'd0, 4'd0, 32'd0, STAT_ABSENT, 32'd0, 10'd0);
        add_row(ACT_SET, 64'hFFFF_0000_1234_5678, 4'd0, 32'd1, STAT_OK, 32'd0, 10'd1);
        add_row(ACT_GET, 64'd0, 4'd0, 32'd0, STAT_OK, 32'd1, 10'd1);
        add_row(ACT_SET, ~64'd0, 4'd8, ~32'd0, STAT_OK, 32'd0, 10'd2);
        add_row(ACT_GET, ~64'd0, 4'd15, 32'd0, STAT_OK, ~32'd0, 10'd2);
        add_row(ACT_SET, 64'h0000_0000_0043_4241, 4'd3, 32'd5, STAT_OK, 32'd0, 10'd3);
        add_row(ACT_GET, 64'h0000_0000_0063_6261, 4'd3, 32'd0, STAT_ABSENT, 32'd0, 10'd3);
        add_row(ACT_GET, 64'hDEAD_BEEF_1243_4241, 4'd3, 32'd0, STAT_OK, 32'd5, 10'd3);
        add_row(ACT_SET, 64'd0, 4'd2, 32'd7, STAT_OK, 32'd0, 10'd4);
        add_row(ACT_GET, 64'd0, 4'd1, 32'd0, STAT_ABSENT, 32'd0, 10'd4);
        add_row(ACT_GET, 64'hFF00_0000_0000_0000, 4'd2, 32'd0, STAT_OK, 32'd7, 10'd4);
        add_row(ACT_SET, 64'h0000_0000_0043_4241, 4'd3, 32'd0, STAT_OK, 32'd0, 10'd3);
        add_row(ACT_GET, 64'h0000_0000_0043_4241, 4'd3, 32'd0, STAT_ABSENT, 32'd0, 10'd3);
        add_row(ACT_SET, 64'h1122_3344_5566_7788, 4'd8, 32'd0, STAT_OK, 32'd0, 10'd3);
        add_row(ACT_BAD, ~64'd0, 4'd8, ~32'd0, STAT_OK, 32'd0, 10'd3);
        add_row(ACT_SET, 64'h0000_0000_0043_4241, 4'd3, 32'd9, STAT_OK, 32'd0, 10'd4);
        add_row(ACT_SET, ~64'd0, 4'd8, 32'd2, STAT_OK, 32'd0, 10'd4);
        add_row(ACT_GET, ~64'd0, 4'd8, 32'd0, STAT_OK, 32'd2, 10'd4);
        add_row(ACT_CLR, 64'd0, 4'd0, 32'd0, STAT_OK, 32'd0, 10'd0);
        add_row(ACT_GET, ~64'd0, 4'd8, 32'd0, STAT_ABSENT, 32'd0, 10'd0);
        foreach (table_rows[i]) begin
            r = apply_op(table_rows[i].act, table_rows[i].key, table_rows[i].len,
                         table_rows[i].val);
            send_op(table_rows[i].act, table_rows[i].key, table_rows[i].len,
                    table_rows[i].val, table_rows[i].reply);
        end

        random_ops(300);

        // fill past the load limit with fresh keys, with gets mixed in
        for (int n = 0; n < 940; n++) begin
            key = {$urandom, $urandom};
            if (n % 10 == 9) predict_and_send(ACT_GET, key_pool[n % 24], len_pool[n % 24], 0);
            else predict_and_send(ACT_SET, key, 4'd8, $urandom | 32'd1);
        end
        // mode write while entries are live must be ignored
        write_case(32'd1);
        random_ops(40);
        predict_and_send(ACT_CLR, '0, '0, '0);

        write_case(32'd1);
        random_ops(240);
        predict_and_send(ACT_CLR, '0, '0, '0);
        write_case(32'd0);
        random_ops(20);

        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("%0d items sent, %0d results checked: %0d hits, %0d full replies",
                 n_items, n_replies, n_found, n_full);
        $display("covered both case modes, ignored mode write, tombstones, clears, load limit");
        if (errors == 0) $display("brent_hash_table_engine regression: pass");
        else $display("brent_hash_table_engine regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/bhte_pkg.sv
rtl/bhte_front.sv
rtl/bhte_queue.sv
rtl/bhte_back.sv
rtl/brent_hash_table_engine.sv
tb/tb_brent_hash_table_engine.sv
